[rtl/rpse_pkg.sv]
package rpse_pkg;

   localparam int CFG_W     = 11;
   localparam int THR_W     = 8;
   localparam int PIX_W     = 8;
   localparam int TALLY_W   = 20;
   localparam int SPEED_W   = 13;
   localparam int STEER_W   = 16;
   localparam int QUO_W     = 16;
   localparam int CSR_IDX_W = 2;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int FIFO_DEPTH     = 2;

   localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH   = 11'd640;
   localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT  = 11'd480;
   localparam logic [THR_W-1:0] RST_RED_THRESHOLD = 8'd75;

   localparam logic [SPEED_W-1:0]        SPEED_OFFSET = 13'd2560;
   localparam logic signed [SPEED_W-1:0] SPEED_FLOOR  = -13'sd2560;
   localparam logic [STEER_W-1:0]        STEER_OFFSET = 16'd25600;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH   = 2'd0,
      CSR_IMAGE_HEIGHT  = 2'd1,
      CSR_RED_THRESHOLD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] image_width;
      logic [CFG_W-1:0] image_height;
      logic [THR_W-1:0] red_threshold;
   } cfg_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   function automatic int index_width(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

[rtl/rpse_pixel_if.sv]
interface rpse_pixel_if import rpse_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

[rtl/rpse_result_if.sv]
interface rpse_result_if import rpse_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [SPEED_W-1:0] speed_q8;
   logic signed [STEER_W-1:0] steering_q8;
   logic [TALLY_W-1:0]        left_red_count;
   logic [TALLY_W-1:0]        right_red_count;

   modport source (output valid, output speed_q8, output steering_q8,
                   output left_red_count, output right_red_count, input ready);
   modport sink (input valid, input speed_q8, input steering_q8,
                 input left_red_count, input right_red_count, output ready);
endinterface

[rtl/rpse_fifo.sv]
module rpse_fifo import rpse_pkg::*; #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = FIFO_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);

   localparam int AW = index_width(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]     fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full     = (fill_ff == NW'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/rpse_front.sv]
module rpse_front import rpse_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int EW         = $clog2(DEF_MAX_WIDTH + 1),
   parameter int HW         = $clog2(DEF_MAX_HEIGHT + 1),
   parameter int ENTRY_W    = 2 * TALLY_W + EW + HW
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   rpse_pixel_if.sink         req_pixel,
   output logic               queue_push,
   input  logic               queue_full,
   output logic [ENTRY_W-1:0] push_data
);

   localparam int CW  = index_width(MAX_WIDTH);
   localparam int RW  = index_width(MAX_HEIGHT);
   localparam int XWW = CFG_W + EW;
   localparam int XHW = CFG_W + HW;

   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [TALLY_W-1:0] left_ff, left_in;
   logic [TALLY_W-1:0] right_ff, right_in;
   logic [EW-1:0]      eff_w, col_next;
   logic [HW-1:0]      eff_h, row_next;
   logic [PIX_W:0]     green_blue;
   logic               is_red, left_side, row_end, frame_end, fire;

   always_comb begin
      if (cfg.image_width < CFG_W'(2)) begin
         eff_w = EW'(2);
      end else if (XWW'(cfg.image_width) > XWW'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end else begin
         eff_w = EW'(cfg.image_width);
      end
      if (cfg.image_height == '0) begin
         eff_h = HW'(1);
      end else if (XHW'(cfg.image_height) > XHW'(MAX_HEIGHT)) begin
         eff_h = HW'(MAX_HEIGHT);
      end else begin
         eff_h = HW'(cfg.image_height);
      end
   end

   assign green_blue = {1'b0, req_pixel.green} + {1'b0, req_pixel.blue};
   assign is_red     = ({1'b0, req_pixel.red} > green_blue)
                       && (req_pixel.red > cfg.red_threshold);
   assign left_side  = EW'(col_ff) < (eff_w >> 1);
   assign col_next   = EW'(col_ff) + EW'(1);
   assign row_next   = HW'(row_ff) + HW'(1);
   assign row_end    = col_next >= eff_w;
   assign frame_end  = row_end && (row_next >= eff_h);

   assign req_pixel.ready = !(frame_end && queue_full);
   assign fire            = req_pixel.valid && req_pixel.ready;

   always_comb begin
      left_in  = left_ff;
      right_in = right_ff;
      if (is_red && left_side && (left_ff != '1)) begin
         left_in = left_ff + TALLY_W'(1);
      end
      if (is_red && !left_side && (right_ff != '1)) begin
         right_in = right_ff + TALLY_W'(1);
      end
      col_in = col_ff;
      row_in = row_ff;
      if (frame_end) begin
         col_in = '0;
         row_in = '0;
      end else if (row_end) begin
         col_in = '0;
         row_in = row_ff + RW'(1);
      end else begin
         col_in = col_ff + CW'(1);
      end
   end

   assign queue_push = fire && frame_end;
   assign push_data  = {left_in, right_in, eff_w, eff_h};

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         left_ff  <= TALLY_W'(1);
         right_ff <= TALLY_W'(1);
      end else if (fire) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         left_ff  <= frame_end ? TALLY_W'(1) : left_in;
         right_ff <= frame_end ? TALLY_W'(1) : right_in;
      end
   end

endmodule

[rtl/rpse_div.sv]
module rpse_div import rpse_pkg::*; #(
   parameter int DVW = 27,
   parameter int QW  = QUO_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DVW+QW-1:0] dividend,
   input  logic [DVW-1:0]    divisor,
   output logic              done,
   output logic [QW-1:0]     quotient
);

   localparam int KW = $clog2(QW + 1);

   logic [DVW-1:0] rem_ff, rem_in;
   logic [QW-1:0]  dnd_ff, dnd_in;
   logic [DVW-1:0] dsr_ff;
   logic [KW-1:0]  cnt_ff;
   logic           done_ff;
   logic [DVW:0]   trial;
   logic           fits;

   // quotient bits shift in at the bottom as the dividend shifts out at the top
   assign trial = {rem_ff, dnd_ff[QW-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      rem_in = fits ? DVW'(trial - {1'b0, dsr_ff}) : trial[DVW-1:0];
      dnd_in = {dnd_ff[QW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= KW'(QW);
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == KW'(1));
         if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - KW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[DVW+QW-1:QW];
         dnd_ff <= dividend[QW-1:0];
         dsr_ff <= divisor;
      end else if (cnt_ff != '0) begin
         rem_ff <= rem_in;
         dnd_ff <= dnd_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dnd_ff;

endmodule

[rtl/rpse_back.sv]
module rpse_back import rpse_pkg::*; #(
   parameter int EW      = $clog2(DEF_MAX_WIDTH + 1),
   parameter int HW      = $clog2(DEF_MAX_HEIGHT + 1),
   parameter int ENTRY_W = 2 * TALLY_W + EW + HW
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_empty,
   input  logic [ENTRY_W-1:0] pop_data,
   output logic               pop,
   rpse_result_if.source      rsp_result
);

   localparam int PW   = EW + HW;
   localparam int SW   = TALLY_W + 1;
   localparam int S20W = SW + 5;
   localparam int CMPW = max_int(PW, S20W) + 1;
   localparam int DVW  = max_int(PW + 1, SW + 1);
   localparam int DDW  = DVW + QUO_W;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_PROD  = 7'b0000010,
      ST_SPEED = 7'b0000100,
      ST_DIVS  = 7'b0001000,
      ST_STEER = 7'b0010000,
      ST_DIVT  = 7'b0100000,
      ST_RESP  = 7'b1000000
   } state_type;

   state_type                 state_ff, state_in;
   logic [TALLY_W-1:0]        left_ff, right_ff;
   logic [EW-1:0]             w_ff;
   logic [HW-1:0]             h_ff;
   logic [PW-1:0]             p_ff;
   logic [SW-1:0]             s_ff;
   logic signed [SPEED_W-1:0] speed_ff, speed_in;
   logic signed [STEER_W-1:0] steer_ff, steer_in;
   logic [S20W-1:0]           s20;
   logic                      speed_floor;
   logic [PW-1:0]             t;
   logic [DDW-1:0]            d_speed, d_steer, r_ext, t_ext;
   logic [DDW-1:0]            div_dividend;
   logic [DVW-1:0]            div_divisor;
   logic                      div_start, div_done;
   logic [QUO_W-1:0]          div_quotient;

   assign s20         = (S20W'(s_ff) << 4) + (S20W'(s_ff) << 2);
   assign speed_floor = CMPW'(s20) >= CMPW'(p_ff);
   assign t           = PW'(CMPW'(p_ff) - CMPW'(s20));
   assign t_ext       = DDW'(t);
   assign r_ext       = DDW'(right_ff);
   // 2*5120*t + p over 2p, and 2*51200*right + s over 2s
   assign d_speed     = (t_ext << 13) + (t_ext << 11) + DDW'(p_ff);
   assign d_steer     = (((r_ext << 6) + (r_ext << 5) + (r_ext << 2)) << 10) + DDW'(s_ff);

   assign div_start    = ((state_ff == ST_SPEED) && !speed_floor) || (state_ff == ST_STEER);
   assign div_dividend = (state_ff == ST_STEER) ? d_steer : d_speed;
   assign div_divisor  = (state_ff == ST_STEER) ? DVW'({s_ff, 1'b0}) : DVW'({p_ff, 1'b0});

   rpse_div #(
      .DVW (DVW),
      .QW  (QUO_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign pop      = (state_ff == ST_IDLE) && !queue_empty;
   assign speed_in = $signed(SPEED_W'(div_quotient) - SPEED_OFFSET);
   assign steer_in = $signed(STEER_W'(div_quotient) - STEER_OFFSET);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            state_in = ST_SPEED;
         end
         ST_SPEED: begin
            state_in = speed_floor ? ST_STEER : ST_DIVS;
         end
         ST_DIVS: begin
            if (div_done) begin
               state_in = ST_STEER;
            end
         end
         ST_STEER: begin
            state_in = ST_DIVT;
         end
         ST_DIVT: begin
            if (div_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_result.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         {left_ff, right_ff, w_ff, h_ff} <= pop_data;
      end
      if (state_ff == ST_PROD) begin
         p_ff <= PW'(w_ff * h_ff);
         s_ff <= SW'(left_ff) + SW'(right_ff);
      end
      if ((state_ff == ST_SPEED) && speed_floor) begin
         speed_ff <= SPEED_FLOOR;
      end else if ((state_ff == ST_DIVS) && div_done) begin
         speed_ff <= speed_in;
      end
      if ((state_ff == ST_DIVT) && div_done) begin
         steer_ff <= steer_in;
      end
   end

   assign rsp_result.valid           = (state_ff == ST_RESP);
   assign rsp_result.speed_q8        = speed_ff;
   assign rsp_result.steering_q8     = steer_ff;
   assign rsp_result.left_red_count  = left_ff;
   assign rsp_result.right_red_count = right_ff;

endmodule

[rtl/red_pixel_steering_estimator.sv]
// Channel      Direction  Transaction
// req_pixel    in         one RGB pixel, raster order
// rsp_result   out        speed, steering and both red tallies, one per frame
// csr_*        in         register write, index 0 width, 1 height, 2 threshold
//
// Pixels are taken one per cycle; the front end stalls only at the last pixel of a
// frame while the two-entry frame queue is full.
// The back end handles one frame at a time, from queue pop to result: two 16-step
// restoring divisions on one shared divider plus set-up; only one when the speed clamps.
// Reset is synchronous; it clears position, queue and back-end state and sets tallies to one.
// A result waits in the back end's output registers until taken.
module red_pixel_steering_estimator import rpse_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                 clock,
   input  logic                 reset,
   rpse_pixel_if.sink           req_pixel,
   rpse_result_if.source        rsp_result,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data
);

   localparam int EW      = $clog2(MAX_WIDTH + 1);
   localparam int HW      = $clog2(MAX_HEIGHT + 1);
   localparam int ENTRY_W = 2 * TALLY_W + EW + HW;

   cfg_type            cfg_ff;
   logic               queue_push;
   logic               queue_full, queue_empty, queue_pop;
   logic [ENTRY_W-1:0] push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width   <= RST_IMAGE_WIDTH;
         cfg_ff.image_height  <= RST_IMAGE_HEIGHT;
         cfg_ff.red_threshold <= RST_RED_THRESHOLD;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               cfg_ff.image_width <= csr_write_data;
            end
            CSR_IMAGE_HEIGHT: begin
               cfg_ff.image_height <= csr_write_data;
            end
            CSR_RED_THRESHOLD: begin
               cfg_ff.red_threshold <= csr_write_data[THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   rpse_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .EW         (EW),
      .HW         (HW),
      .ENTRY_W    (ENTRY_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_pixel  (req_pixel),
      .queue_push (queue_push),
      .queue_full (queue_full),
      .push_data  (push_data)
   );

   rpse_fifo #(
      .DATA_W (ENTRY_W),
      .DEPTH  (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   rpse_back #(
      .EW      (EW),
      .HW      (HW),
      .ENTRY_W (ENTRY_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop_data    (pop_data),
      .pop         (queue_pop),
      .rsp_result  (rsp_result)
   );

endmodule

[rtl/rpse_checker.sv]
module rpse_checker import rpse_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [SPEED_W-1:0] rsp_speed_q8,
   input logic signed [STEER_W-1:0] rsp_steering_q8,
   input logic [TALLY_W-1:0]        rsp_left_red_count,
   input logic [TALLY_W-1:0]        rsp_right_red_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result presented straight after reset");

   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_speed_q8 >= -13'sd2560) && (rsp_speed_q8 <= 13'sd2560))
      else $error("speed out of range");

   a_steer_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_steering_q8 >= -16'sd25600) && (rsp_steering_q8 <= 16'sd25600))
      else $error("steering out of range");

   a_tallies_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left_red_count != '0) && (rsp_right_red_count != '0))
      else $error("red tally reported as zero");

endmodule

bind red_pixel_steering_estimator rpse_checker u_rpse_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_result.valid),
   .rsp_ready           (rsp_result.ready),
   .rsp_speed_q8        (rsp_result.speed_q8),
   .rsp_steering_q8     (rsp_result.steering_q8),
   .rsp_left_red_count  (rsp_result.left_red_count),
   .rsp_right_red_count (rsp_result.right_red_count)
);

[verif/testbench.sv]
module testbench;
   import rpse_pkg::*;

   localparam int unsigned TALLY_LIMIT    = (1 << TALLY_W) - 1;
   localparam int unsigned BACK_END_SLACK = 80;
   localparam int unsigned CYCLE_LIMIT    = 500000;
   localparam int unsigned PIXEL_BUDGET   = 1975;
   localparam int          PIXEL_BITS     = 3 * PIX_W;

   // index 3 is decoded by nothing; writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] speed_q8;
      logic signed [STEER_W-1:0] steering_q8;
      logic [TALLY_W-1:0]        left_red_count;
      logic [TALLY_W-1:0]        right_red_count;
   } frame_result_type;

   class frame_steering_model;
      logic [CFG_W-1:0] image_width;
      logic [CFG_W-1:0] image_height;
      logic [THR_W-1:0] red_threshold;
      int unsigned      column;
      int unsigned      row;
      int unsigned      left_tally;
      int unsigned      right_tally;
      frame_result_type expected_frames[$];
      int unsigned      mismatches;

      function new();
         image_width   = RST_IMAGE_WIDTH;
         image_height  = RST_IMAGE_HEIGHT;
         red_threshold = RST_RED_THRESHOLD;
         mismatches    = 0;
         restart_frame();
      endfunction

      function void restart_frame();
         column      = 0;
         row         = 0;
         left_tally  = 1;
         right_tally = 1;
      endfunction

      function bit at_frame_start();
         return column == 0 && row == 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
         case (idx)
            CSR_IMAGE_WIDTH:   image_width   = data;
            CSR_IMAGE_HEIGHT:  image_height  = data;
            CSR_RED_THRESHOLD: red_threshold = data[THR_W-1:0];
            default: ;
         endcase
      endfunction

      function void take_pixel(pixel_type px);
         int unsigned       w;
         int unsigned       h;
         int unsigned       r;
         int unsigned       g;
         int unsigned       b;
         bit                red_hit;
         bit                row_end;
         bit                frame_end;
         longint unsigned   p;
         longint unsigned   s;
         longint unsigned   num;
         longint unsigned   steer_mag;
         logic signed [63:0] speed;
         logic signed [63:0] steer;
         frame_result_type  res;

         w = image_width;
         if (w < 2) w = 2;
         if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
         h = image_height;
         if (h < 1) h = 1;
         if (h > DEF_MAX_HEIGHT) h = DEF_MAX_HEIGHT;

         r = px.red;
         g = px.green;
         b = px.blue;
         red_hit = (r > g + b) && (r > red_threshold);
         if (red_hit) begin
            if (column < w / 2) begin
               if (left_tally < TALLY_LIMIT) left_tally++;
            end else if (right_tally < TALLY_LIMIT) begin
               right_tally++;
            end
         end

         row_end   = (column + 1 >= w);
         frame_end = row_end && (row + 1 >= h);
         if (!frame_end) begin
            if (row_end) begin
               column = 0;
               row++;
            end else begin
               column++;
            end
            return;
         end

         p = longint'(w) * longint'(h);
         s = longint'(left_tally) + longint'(right_tally);
         if (102400 * s >= 5120 * p) begin
            speed = -2560;
         end else begin
            num   = 5120 * p - 102400 * s;
            speed = $signed((2 * num + p) / (2 * p)) - 2560;
         end
         steer_mag = (102400 * longint'(right_tally) + s) / (2 * s);
         steer     = $signed(steer_mag) - 25600;

         res.speed_q8        = speed[SPEED_W-1:0];
         res.steering_q8     = steer[STEER_W-1:0];
         res.left_red_count  = left_tally[TALLY_W-1:0];
         res.right_red_count = right_tally[TALLY_W-1:0];
         expected_frames.push_back(res);
         restart_frame();
      endfunction

      function void compare_field(string field, logic signed [31:0] want,
                                  logic signed [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_frame_result(frame_result_type got);
         frame_result_type want;
         if (expected_frames.size() == 0) begin
            $error("frame result with no frame outstanding");
            mismatches++;
            return;
         end
         want = expected_frames.pop_front();
         compare_field("speed_q8", want.speed_q8, got.speed_q8);
         compare_field("steering_q8", want.steering_q8, got.steering_q8);
         compare_field("left_red_count", want.left_red_count, got.left_red_count);
         compare_field("right_red_count", want.right_red_count, got.right_red_count);
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_write_data;

   rpse_pixel_if  pixel_bus();
   rpse_result_if result_bus();

   frame_steering_model model;
   int unsigned sender_gap_pct     = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned hold_off_left      = 0;
   int unsigned pixels_sent        = 0;
   int unsigned cycle_count        = 0;

   red_pixel_steering_estimator dut (
      .clock            (clock),
      .reset            (reset),
      .req_pixel        (pixel_bus),
      .rsp_result       (result_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // result sink: random back-pressure, or a long hold-off when requested
   always @(negedge clock) begin
      if (hold_off_left != 0) begin
         result_bus.ready <= 1'b0;
         hold_off_left--;
      end else begin
         result_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && result_bus.valid && result_bus.ready)
         model.check_frame_result({result_bus.speed_q8, result_bus.steering_q8,
                                   result_bus.left_red_count, result_bus.right_red_count});
   end

   task automatic set_idling(idle_mode_type m);
      case (m)
         IDLE_NONE: begin
            sender_gap_pct     = 0;
            receiver_stall_pct = 0;
         end
         IDLE_SENDER: begin
            sender_gap_pct     = 49;
            receiver_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            sender_gap_pct     = 0;
            receiver_stall_pct = 49;
         end
         default: begin
            sender_gap_pct     = 30;
            receiver_stall_pct = 30;
         end
      endcase
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      model.set_register(idx, data);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_pixel(pixel_type px);
      while (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct) begin
         @(negedge clock);
         pixel_bus.valid <= 1'b0;
      end
      @(negedge clock);
      pixel_bus.valid <= 1'b1;
      pixel_bus.red   <= px.red;
      pixel_bus.green <= px.green;
      pixel_bus.blue  <= px.blue;
      do @(posedge clock); while (!pixel_bus.ready);
      model.take_pixel(px);
      pixels_sent++;
   endtask

   function automatic pixel_type random_pixel(int unsigned red_pct);
      pixel_type   px;
      int unsigned r;
      int unsigned g;
      if ($urandom_range(99) < red_pct) begin
         r = $urandom_range(255, 1);
         g = $urandom_range(r - 1, 0);
         px.red   = PIX_W'(r);
         px.green = PIX_W'(g);
         px.blue  = PIX_W'($urandom_range(r - 1 - g, 0));
      end else begin
         px = PIXEL_BITS'($urandom);
      end
      return px;
   endfunction

   task automatic send_frame(int unsigned red_pct);
      do send_pixel(random_pixel(red_pct)); while (!model.at_frame_start());
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      pixel_bus.valid <= 1'b0;
      while (model.expected_frames.size() != 0) @(posedge clock);
   endtask

   task automatic settle();
      wait_for_results();
      repeat (BACK_END_SLACK) @(posedge clock);
   endtask

   initial begin
      int unsigned phase;
      int unsigned frames;
      int unsigned red_pct;
      logic [CFG_W-1:0] width_val;
      logic [CFG_W-1:0] height_val;
      logic [THR_W-1:0] threshold_val;

      model            = new();
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      pixel_bus.valid  = 1'b0;
      pixel_bus.red    = '0;
      pixel_bus.green  = '0;
      pixel_bus.blue   = '0;
      result_bus.ready = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_idling(IDLE_NONE);

      // 4x2 frame, threshold left at its reset value
      write_register(CSR_IMAGE_WIDTH, 11'd4);
      write_register(CSR_IMAGE_HEIGHT, 11'd2);
      send_pixel({8'd0, 8'd0, 8'd0});
      send_pixel({8'd255, 8'd127, 8'd127});
      send_pixel({8'd255, 8'd128, 8'd127});
      send_pixel({8'd76, 8'd0, 8'd0});
      send_pixel({8'd75, 8'd0, 8'd0});
      send_pixel({8'd255, 8'd255, 8'd255});
      send_pixel({8'd200, 8'd100, 8'd99});
      send_pixel({8'd76, 8'd37, 8'd38});
      settle();

      // spare index ignored; zero width and height clamp up; threshold at top
      write_register(CSR_SPARE_INDEX, 11'd5);
      write_register(CSR_IMAGE_WIDTH, 11'd0);
      write_register(CSR_IMAGE_HEIGHT, 11'd0);
      write_register(CSR_RED_THRESHOLD, 11'd255);
      send_pixel({8'd255, 8'd0, 8'd0});
      send_pixel({8'd255, 8'd0, 8'd0});
      settle();

      // oversize width clamps; shrinking it mid-row ends the row
      write_register(CSR_IMAGE_WIDTH, 11'd2047);
      write_register(CSR_IMAGE_HEIGHT, 11'd1);
      write_register(CSR_RED_THRESHOLD, 11'd254);
      send_pixel({8'd255, 8'd0, 8'd0});
      send_pixel({8'd255, 8'd0, 8'd0});
      send_pixel({8'd255, 8'd255, 8'd255});
      send_pixel({8'd0, 8'd0, 8'd0});
      send_pixel({8'd255, 8'd0, 8'd1});
      send_pixel({8'd254, 8'd0, 8'd0});
      settle();
      write_register(CSR_IMAGE_WIDTH, 11'd4);
      send_pixel({8'd255, 8'd0, 8'd0});
      settle();

      // oversize height clamps; shrinking it mid-frame ends the frame
      write_register(CSR_IMAGE_HEIGHT, 11'd2047);
      write_register(CSR_IMAGE_WIDTH, 11'd2);
      write_register(CSR_RED_THRESHOLD, 11'd10);
      send_pixel({8'd11, 8'd0, 8'd0});
      send_pixel({8'd11, 8'd5, 8'd5});
      send_pixel({8'd10, 8'd0, 8'd0});
      send_pixel({8'd200, 8'd0, 8'd0});
      settle();
      write_register(CSR_IMAGE_HEIGHT, 11'd2);
      send_pixel({8'd255, 8'd0, 8'd0});
      send_pixel({8'd0, 8'd255, 8'd0});
      settle();

      phase = 0;
      while (pixels_sent < PIXEL_BUDGET) begin
         set_idling(idle_mode_type'(phase % 4));
         if (phase == 1) begin
            // sink held off so the frame queue fills and input stalls
            write_register(CSR_IMAGE_WIDTH, 11'd2);
            write_register(CSR_IMAGE_HEIGHT, 11'd1);
            write_register(CSR_RED_THRESHOLD, 11'd0);
            hold_off_left = 400;
            repeat (40) send_pixel(random_pixel(50));
            wait_for_results();
            repeat (10) send_pixel(random_pixel(50));
         end else if (phase == 2) begin
            // one full-width row
            write_register(CSR_IMAGE_WIDTH, 11'd2047);
            write_register(CSR_IMAGE_HEIGHT, 11'd1);
            write_register(CSR_RED_THRESHOLD, CFG_W'($urandom_range(255)));
            send_frame(60);
         end else begin
            width_val  = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(1))
                                                  : CFG_W'($urandom_range(20, 2));
            height_val = ($urandom_range(9) == 0) ? 11'd0 : CFG_W'($urandom_range(8, 1));
            case ($urandom_range(5))
               0:       threshold_val = 8'd0;
               1:       threshold_val = 8'd255;
               default: threshold_val = THR_W'($urandom_range(255));
            endcase
            write_register(CSR_RED_THRESHOLD, CFG_W'(threshold_val));
            write_register(CSR_IMAGE_HEIGHT, height_val);
            write_register(CSR_IMAGE_WIDTH, width_val);
            frames = $urandom_range(4, 1);
            repeat (frames) begin
               red_pct = ($urandom_range(3) == 0) ? 100 * $urandom_range(1) : $urandom_range(100);
               send_frame(red_pct);
            end
         end
         settle();
         phase++;
      end

      settle();
      if (model.mismatches == 0 && model.expected_frames.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
